FILE: hw/rtl/ed_pkg.sv
// Edit distance engine package: sizes, the token passed along the cell chain
// and the load/init command broadcast to the cells.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ed_pkg;

	localparam int MAX_LEN = 64;
	localparam int LEN_W   = $clog2(MAX_LEN + 2);
	localparam int SYM_W   = 8;
	localparam int DIST_W  = 7;

	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic             valid;
		logic             has_sym;
		logic             last;
		logic             tl;
		logic [SYM_W-1:0] sym;
		len_t             left;
		len_t             diag;
		len_t             res;
	} ed_tok_t;

	typedef struct packed {
		logic             we;
		logic             init;
		len_t             idx;
		logic [SYM_W-1:0] sym;
	} ed_load_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ed_cell.sv
// One column cell of the edit distance chain: holds a reference symbol and
// one row entry, updates it per query token. Depends on ed_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ed_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ed_pkg::len_t  idx,
	input  wire ed_pkg::len_t  ref_len,
	input  wire ed_pkg::ed_load_t ld,
	input  wire ed_pkg::ed_tok_t  tok_in,
	output ed_pkg::ed_tok_t    tok_out
);

	logic [ed_pkg::SYM_W-1:0] ref_q;
	ed_pkg::len_t             d_q;
	ed_pkg::len_t             up;
	ed_pkg::len_t             lf;
	ed_pkg::len_t             dg;
	ed_pkg::len_t             best;
	logic                     cost;
	ed_pkg::ed_tok_t          tok_nxt;

	always_comb begin
		cost = (ref_q != tok_in.sym);
		up   = d_q + ed_pkg::len_t'(1);
		lf   = tok_in.left + ed_pkg::len_t'(1);
		dg   = tok_in.diag + ed_pkg::len_t'(cost);
		best = up;
		if (lf < best) begin
			best = lf;
		end
		if (dg < best) begin
			best = dg;
		end
		tok_nxt      = tok_in;
		tok_nxt.left = tok_in.has_sym ? best : d_q;
		tok_nxt.diag = d_q;
		if (tok_in.valid && tok_in.last && idx == ref_len) begin
			tok_nxt.res = tok_in.has_sym ? best : d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.we && ld.idx == idx) begin
			ref_q <= ld.sym;
		end
		if (en) begin
			if (ld.init) begin
				d_q <= idx;
			end else if (tok_in.valid && tok_in.last) begin
				d_q <= idx;
			end else if (tok_in.valid && tok_in.has_sym) begin
				d_q <= best;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= tok_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ed_ctrl.sv
// Head of the edit distance chain: reference length, query count (row entry
// zero), overflow flags and the token fed into the first cell. Depends on ed_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ed_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     acc,
	input  wire logic [ed_pkg::SYM_W-1:0] symbol,
	input  wire logic                     is_query,
	input  wire logic                     is_last,
	input  wire logic                     is_empty,
	output ed_pkg::len_t                  ref_len,
	output ed_pkg::ed_load_t              ld,
	output ed_pkg::ed_tok_t               tok_out
);

	localparam ed_pkg::len_t MAX = ed_pkg::len_t'(ed_pkg::MAX_LEN);

	ed_pkg::len_t    len_q;
	ed_pkg::len_t    qcnt_q;
	logic            ref_over_q;
	logic            q_over_q;
	logic            committed_q;
	ed_pkg::len_t    len_base;
	logic            over_base;
	logic            live;
	logic            sym_ok;
	logic            q_over_nxt;
	ed_pkg::len_t    qcnt_nxt;
	ed_pkg::ed_tok_t tok_nxt;

	assign ref_len = len_q;

	always_comb begin
		live       = acc && !(is_empty && !is_last);
		len_base   = committed_q ? '0 : len_q;
		over_base  = committed_q ? 1'b0 : ref_over_q;
		ld.sym     = symbol;
		ld.idx     = len_base + ed_pkg::len_t'(1);
		ld.we      = live && !is_query && !is_empty && len_base < MAX;
		ld.init    = live && !is_query && is_last;
		sym_ok     = !is_empty && qcnt_q < MAX;
		q_over_nxt = q_over_q || (!is_empty && qcnt_q >= MAX);
		qcnt_nxt   = qcnt_q + ed_pkg::len_t'(sym_ok);
		tok_nxt         = '0;
		tok_nxt.valid   = live && is_query && committed_q && (sym_ok || is_last);
		tok_nxt.has_sym = sym_ok;
		tok_nxt.last    = is_last;
		tok_nxt.tl      = ref_over_q || q_over_nxt;
		tok_nxt.sym     = symbol;
		tok_nxt.left    = qcnt_nxt;
		tok_nxt.diag    = qcnt_q;
		tok_nxt.res     = qcnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			qcnt_q      <= '0;
			ref_over_q  <= 1'b0;
			q_over_q    <= 1'b0;
			committed_q <= 1'b1;
		end else if (live) begin
			if (!is_query) begin
				len_q       <= ld.we ? ld.idx : len_base;
				ref_over_q  <= over_base || (!is_empty && len_base >= MAX);
				committed_q <= is_last;
				if (is_last) begin
					qcnt_q   <= '0;
					q_over_q <= 1'b0;
				end
			end else if (committed_q) begin
				if (is_last) begin
					qcnt_q   <= '0;
					q_over_q <= 1'b0;
				end else begin
					qcnt_q   <= qcnt_nxt;
					q_over_q <= q_over_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= tok_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/edit_distance_engine.sv
// Edit distance engine top level: head control, a chain of MAX_LEN cells and
// the result register. Depends on ed_pkg, ed_ctrl and ed_cell.
//
//  channel | signals                                       | transfer when
//  --------+-----------------------------------------------+-----------------------
//  in      | in_valid in_ready symbol is_query is_last     | in_valid && in_ready
//          | is_empty                                      |
//  out     | out_valid out_ready distance too_long         | out_valid && out_ready
//
// Query symbols enter one per cycle while the chain is not frozen; a query's last
// item passes the head register and every cell register before the result register.
// Reference items wait until no query token is left in the chain.
// The chain freezes only while a finished token sits at its end and the
// result register is still full. Reset leaves an empty, committed reference.
`timescale 1ns / 1ps
`default_nettype none
module edit_distance_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [ed_pkg::SYM_W-1:0]  symbol,
	input  wire logic                      is_query,
	input  wire logic                      is_last,
	input  wire logic                      is_empty,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [ed_pkg::DIST_W-1:0]      distance,
	output logic                           too_long
);

	ed_pkg::ed_tok_t            tok [0:ed_pkg::MAX_LEN];
	logic [ed_pkg::MAX_LEN:0]   vld;
	ed_pkg::len_t               ref_len;
	ed_pkg::ed_load_t           ld;
	ed_pkg::ed_tok_t            tail;
	logic                       advance;
	logic                       chain_empty;
	logic                       acc;

	assign tail        = tok[ed_pkg::MAX_LEN];
	assign advance     = !(tail.valid && tail.last && out_valid && !out_ready);
	assign chain_empty = ~|vld;
	assign in_ready    = is_query ? advance : chain_empty;
	assign acc         = in_valid && in_ready;

	ed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.acc      (acc),
		.symbol   (symbol),
		.is_query (is_query),
		.is_last  (is_last),
		.is_empty (is_empty),
		.ref_len  (ref_len),
		.ld       (ld),
		.tok_out  (tok[0])
	);

	assign vld[0] = tok[0].valid;

	for (genvar k = 1; k <= ed_pkg::MAX_LEN; k++) begin : g_cell
		ed_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (advance),
			.idx     (ed_pkg::len_t'(k)),
			.ref_len (ref_len),
			.ld      (ld),
			.tok_in  (tok[k-1]),
			.tok_out (tok[k])
		);
		assign vld[k] = tok[k].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && tail.valid && tail.last) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tail.valid && tail.last) begin
			distance <= tail.tl ? ed_pkg::DIST_W'(ed_pkg::MAX_LEN)
			                    : ed_pkg::DIST_W'(tail.res);
			too_long <= tail.tl;
		end
	end

endmodule
`default_nettype wire
